// ===== src/tcpop_pkg.sv =====
// Shared types and constants of the TCP option parser.
// No dependencies; every other file of the block but tcpop_if.sv imports this package.
package tcpop_pkg;

   localparam int MAX_AREA_BYTES_DEF  = 40;
   localparam int MAX_SACK_BLOCKS_DEF = 4;
   localparam int RSP_QUEUE_DEPTH     = 4;

   localparam logic [7:0] KIND_EOL    = 8'd0;
   localparam logic [7:0] KIND_NOP    = 8'd1;
   localparam logic [7:0] KIND_MSS    = 8'd2;
   localparam logic [7:0] KIND_WSCALE = 8'd3;
   localparam logic [7:0] KIND_SACKOK = 8'd4;
   localparam logic [7:0] KIND_SACK   = 8'd5;
   localparam logic [7:0] KIND_TSTAMP = 8'd8;
   localparam logic [7:0] KIND_AUTH   = 8'd29;

   localparam logic [7:0] LEN_MSS    = 8'd4;
   localparam logic [7:0] LEN_WSCALE = 8'd3;
   localparam logic [7:0] LEN_SACKOK = 8'd2;
   localparam logic [7:0] LEN_TSTAMP = 8'd10;
   localparam logic [7:0] LEN_MIN    = 8'd2;

   typedef enum logic [1:0] {
      PH_KIND = 2'd0,
      PH_LEN  = 2'd1,
      PH_BODY = 2'd2,
      PH_STOP = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      RK_MSS     = 3'd0,
      RK_WSCALE  = 3'd1,
      RK_SACKOK  = 3'd2,
      RK_SACKBLK = 3'd3,
      RK_TSTAMP  = 3'd4,
      RK_AUTH    = 3'd5,
      RK_DONE    = 3'd6
   } rkind_type;

   typedef enum logic [1:0] {
      STOP_NONE      = 2'd0,
      STOP_EXHAUSTED = 2'd1,
      STOP_EOL       = 2'd2,
      STOP_MALFORMED = 2'd3
   } stop_type;

   typedef struct packed {
      rkind_type   kind;
      logic [31:0] value_a;
      logic [31:0] value_b;
      stop_type    reason;
      logic        last;
   } result_type;

   // Up to two result words per byte; word0 always fills first.
   typedef struct packed {
      logic [1:0] count;
      result_type word0;
      result_type word1;
   } push_type;

endpackage

// ===== src/tcpop_if.sv =====
// Handshake channels of the TCP option parser: byte request and result word.
// No dependencies.
interface tcpop_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] option_byte;
   logic       first;
   logic [5:0] area_length;

   modport source (output valid, option_byte, first, area_length, input ready);
   modport sink   (input valid, option_byte, first, area_length, output ready);
endinterface

interface tcpop_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  result_kind;
   logic [31:0] value_a;
   logic [31:0] value_b;
   logic [1:0]  stop_reason;
   logic        last;

   modport source (output valid, result_kind, value_a, value_b, stop_reason, last,
                   input ready);
   modport sink   (input valid, result_kind, value_a, value_b, stop_reason, last,
                   output ready);
endinterface

// ===== src/tcpop_parse.sv =====
// Option walk: per-segment parse state, one byte per accepted word.
// Produces up to two result words per byte. Depends on tcpop_pkg.
module tcpop_parse #(
   parameter int MAX_AREA_BYTES  = tcpop_pkg::MAX_AREA_BYTES_DEF,
   parameter int MAX_SACK_BLOCKS = tcpop_pkg::MAX_SACK_BLOCKS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         option_byte,
   input  logic               first,
   input  logic [5:0]         area_length,
   output tcpop_pkg::push_type push
);
   import tcpop_pkg::*;

   localparam logic [5:0] AREA_MAX = 6'(MAX_AREA_BYTES);
   localparam logic [2:0] SACK_MAX = 3'(MAX_SACK_BLOCKS);

   typedef struct packed {
      logic       hit;
      result_type word;
   } opt_type;

   logic [5:0]  pos_ff, pos_in, pos_e;
   phase_type   phase_ff, phase_in, phase_e;
   logic [7:0]  kind_ff, kind_in, kind_e;
   logic [7:0]  len_ff, len_in, len_e;
   logic [5:0]  off_ff, off_in, off_e;
   logic [31:0] acc_a_ff, acc_a_in, acc_a_e;
   logic [31:0] acc_b_ff, acc_b_in, acc_b_e;
   logic [2:0]  blk_ff, blk_in, blk_e;
   stop_type    stop_ff, stop_in, stop_e;

   logic [5:0]  area_c;
   logic [5:0]  rel;
   opt_type     opt;
   logic        done;
   result_type  done_word;

   function automatic opt_type finish(input logic [7:0] k, input logic [7:0] l,
                                      input logic [31:0] a, input logic [31:0] b);
      opt_type r;
      r = '0;
      r.word.reason = STOP_NONE;
      if (k == KIND_MSS && l == LEN_MSS) begin
         r.hit = 1'b1;
         r.word.kind = RK_MSS;
         r.word.value_a = {16'd0, a[15:0]};
      end else if (k == KIND_WSCALE && l == LEN_WSCALE) begin
         r.hit = 1'b1;
         r.word.kind = RK_WSCALE;
         r.word.value_a = {24'd0, a[7:0]};
      end else if (k == KIND_SACKOK && l == LEN_SACKOK) begin
         r.hit = 1'b1;
         r.word.kind = RK_SACKOK;
      end else if (k == KIND_TSTAMP && l == LEN_TSTAMP) begin
         r.hit = 1'b1;
         r.word.kind = RK_TSTAMP;
         r.word.value_a = a;
         r.word.value_b = b;
      end else if (k == KIND_AUTH) begin
         r.hit = 1'b1;
         r.word.kind = RK_AUTH;
      end
      return r;
   endfunction

   always_comb begin
      area_c = (area_length > AREA_MAX) ? AREA_MAX : area_length;

      if (first) begin
         pos_e   = '0;
         phase_e = PH_KIND;
         kind_e  = '0;
         len_e   = '0;
         off_e   = '0;
         acc_a_e = '0;
         acc_b_e = '0;
         blk_e   = '0;
         stop_e  = STOP_NONE;
      end else begin
         pos_e   = pos_ff;
         phase_e = phase_ff;
         kind_e  = kind_ff;
         len_e   = len_ff;
         off_e   = off_ff;
         acc_a_e = acc_a_ff;
         acc_b_e = acc_b_ff;
         blk_e   = blk_ff;
         stop_e  = stop_ff;
      end

      pos_in   = pos_e;
      phase_in = phase_e;
      kind_in  = kind_e;
      len_in   = len_e;
      off_in   = off_e;
      acc_a_in = acc_a_e;
      acc_b_in = acc_b_e;
      blk_in   = blk_e;
      stop_in  = stop_e;
      opt      = '0;
      done     = 1'b0;
      rel      = off_e - 6'd2;

      if (pos_e < area_c) begin
         case (phase_e)
            PH_KIND: begin
               if (option_byte == KIND_EOL) begin
                  stop_in  = STOP_EOL;
                  phase_in = PH_STOP;
               end else if (option_byte != KIND_NOP) begin
                  kind_in = option_byte;
                  if ({1'b0, pos_e} + 7'd1 >= {1'b0, area_c}) begin
                     stop_in  = STOP_MALFORMED;
                     phase_in = PH_STOP;
                  end else begin
                     phase_in = PH_LEN;
                  end
               end
            end
            PH_LEN: begin
               if (option_byte < LEN_MIN ||
                   {3'd0, pos_e} + {1'b0, option_byte} > {3'd0, area_c} + 9'd1) begin
                  stop_in  = STOP_MALFORMED;
                  phase_in = PH_STOP;
               end else begin
                  len_in   = option_byte;
                  acc_a_in = '0;
                  acc_b_in = '0;
                  blk_in   = '0;
                  off_in   = 6'd2;
                  if (option_byte == LEN_MIN) begin
                     opt      = finish(kind_e, option_byte, 32'd0, 32'd0);
                     phase_in = PH_KIND;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               if (kind_e == KIND_SACK) begin
                  if (!rel[2]) acc_a_in = {acc_a_e[23:0], option_byte};
                  else         acc_b_in = {acc_b_e[23:0], option_byte};
                  if (rel[2:0] == 3'd7 && blk_e < SACK_MAX) begin
                     opt.hit          = 1'b1;
                     opt.word.kind    = RK_SACKBLK;
                     opt.word.value_a = acc_a_in;
                     opt.word.value_b = acc_b_in;
                     opt.word.reason  = STOP_NONE;
                     opt.word.last    = 1'b0;
                     blk_in           = blk_e + 3'd1;
                  end
               end else if (rel < 6'd4) begin
                  acc_a_in = {acc_a_e[23:0], option_byte};
               end else begin
                  acc_b_in = {acc_b_e[23:0], option_byte};
               end
               if ({2'd0, off_e} + 8'd1 >= len_e) begin
                  phase_in = PH_KIND;
                  if (kind_e != KIND_SACK) opt = finish(kind_e, len_e, acc_a_in, acc_b_in);
               end else begin
                  off_in = off_e + 6'd1;
               end
            end
            default: begin
            end
         endcase
         done   = ({1'b0, pos_e} + 7'd1 == {1'b0, area_c});
         pos_in = pos_e + 6'd1;
      end

      done_word         = '0;
      done_word.kind    = RK_DONE;
      done_word.reason  = (stop_in != STOP_NONE) ? stop_in : STOP_EXHAUSTED;
      done_word.last    = 1'b1;

      push = '0;
      if (accept) begin
         push.count = {1'b0, opt.hit} + {1'b0, done};
         push.word0 = opt.hit ? opt.word : done_word;
         push.word1 = done_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         phase_ff <= PH_KIND;
         kind_ff  <= '0;
         len_ff   <= '0;
         off_ff   <= '0;
         acc_a_ff <= '0;
         acc_b_ff <= '0;
         blk_ff   <= '0;
         stop_ff  <= STOP_NONE;
      end else if (accept) begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         len_ff   <= len_in;
         off_ff   <= off_in;
         acc_a_ff <= acc_a_in;
         acc_b_ff <= acc_b_in;
         blk_ff   <= blk_in;
         stop_ff  <= stop_in;
      end
   end

   a_two_words_end_in_done: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> (push.word1.last && !push.word0.last))
      else $error("second word of a byte is not the done word");

   a_done_has_reason: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0 && push.word0.last) |-> push.word0.reason != STOP_NONE)
      else $error("done word without stop reason");

   a_stop_phase_coded: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_STOP |-> stop_ff != STOP_NONE)
      else $error("stopped walk without stop code");

   a_sack_limit: assert property (@(posedge clock) disable iff (reset)
      blk_ff <= SACK_MAX)
      else $error("SACK block count beyond limit");

endmodule

// ===== src/tcpop_fifo.sv =====
// Result queue: takes up to two words per cycle while room2 is high, gives one per cycle on each pop.
// Depends on tcpop_pkg.
module tcpop_fifo #(
   parameter int DEPTH = tcpop_pkg::RSP_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tcpop_pkg::push_type  push,
   input  logic                 pop,
   output logic                 room2,
   output logic                 out_valid,
   output tcpop_pkg::result_type out_word
);
   import tcpop_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   result_type        entries_ff [DEPTH];
   logic [PW-1:0]     wr_ff, wr_in, wr_1, wr_2;
   logic [PW-1:0]     rd_ff, rd_in;
   logic [CW-1:0]     count_ff, count_in;

   function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
      logic [PW-1:0] r;
      r = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
      return r;
   endfunction

   always_comb begin
      wr_1     = inc(wr_ff);
      wr_2     = inc(wr_1);
      wr_in    = (push.count == 2'd2) ? wr_2 : (push.count == 2'd1) ? wr_1 : wr_ff;
      rd_in    = pop ? inc(rd_ff) : rd_ff;
      count_in = count_ff + CW'(push.count) - CW'(pop);
   end

   assign room2     = (count_ff <= CW'(DEPTH - 2));
   assign out_valid = (count_ff != '0);
   assign out_word  = entries_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entries_ff[wr_ff] <= push.word0;
      if (push.count == 2'd2) entries_ff[wr_1]  <= push.word1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("result queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty result queue");

   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> {1'b0, count_ff} + (CW + 1)'(push.count) <= (CW + 1)'(DEPTH))
      else $error("push without room");

endmodule

// ===== src/tcp_option_parser_top.sv =====
// TCP option parser, top level: request/result channels around the option
// walk and the result queue. Depends on tcpop_pkg, tcpop_if, tcpop_parse, tcpop_fifo.
//
// Usage:
//   req_if carries one byte of the TCP option area per word, with first set on
//   the opening byte of a segment and area_length (header length minus 20) on
//   every byte. rsp_if carries result words: MSS, window scale, SACK permitted,
//   SACK blocks up to MAX_SACK_BLOCKS, timestamps, auth option presence, and one
//   done word with last set and the stop reason on the final byte of the area.
//   Result words are registered in the queue before rsp_if offers them.
//   Throughput: one byte per cycle when ready. A byte can cause two words (an option
//   closing on the final byte plus done); a four-word queue absorbs these, and
//   req_if.ready drops only while the queue lacks room for two words.
//   Stall: when rsp_if.ready is low, words wait in the queue; input keeps
//   flowing until the queue holds three or more words.
//   Reset: synchronous, clears the parse state and empties the queue; words
//   not yet delivered are lost.
module tcp_option_parser_top #(
   parameter int MAX_AREA_BYTES  = tcpop_pkg::MAX_AREA_BYTES_DEF,
   parameter int MAX_SACK_BLOCKS = tcpop_pkg::MAX_SACK_BLOCKS_DEF
) (
   input logic         clock,
   input logic         reset,
   tcpop_req_if.sink   req_if,
   tcpop_rsp_if.source rsp_if
);
   import tcpop_pkg::*;

   push_type   push;
   logic       room2;
   logic       accept;
   logic       q_valid;
   result_type q_word;

   assign req_if.ready = room2;
   assign accept       = req_if.valid && room2;

   tcpop_parse #(
      .MAX_AREA_BYTES  (MAX_AREA_BYTES),
      .MAX_SACK_BLOCKS (MAX_SACK_BLOCKS)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .option_byte (req_if.option_byte),
      .first       (req_if.first),
      .area_length (req_if.area_length),
      .push        (push)
   );

   tcpop_fifo #(
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (q_valid && rsp_if.ready),
      .room2     (room2),
      .out_valid (q_valid),
      .out_word  (q_word)
   );

   assign rsp_if.valid       = q_valid;
   assign rsp_if.result_kind = q_word.kind;
   assign rsp_if.value_a     = q_word.value_a;
   assign rsp_if.value_b     = q_word.value_b;
   assign rsp_if.stop_reason = q_word.reason;
   assign rsp_if.last        = q_word.last;

endmodule

// ===== sim/tcpop_result_check.sv =====
`timescale 1ns / 100ps
// Result checker for the TCP option parser: predicts result words from accepted
// option bytes and compares them with the words the block delivers.
// Depends on tcpop_pkg and the channel interfaces in tcpop_if.
module tcpop_result_check (
   input  logic clock,
   input  logic reset,
   tcpop_req_if req,
   tcpop_rsp_if rsp,
   output int   mismatches,
   output int   pending
);
   import tcpop_pkg::*;

   logic [5:0]  walk_pos;
   phase_type   walk_phase;
   logic [7:0]  opt_kind;
   logic [7:0]  opt_len;
   logic [5:0]  opt_offset;
   logic [31:0] acc_a;
   logic [31:0] acc_b;
   logic [2:0]  sack_blocks;
   stop_type    walk_stop;
   result_type  expected_words[$];
   result_type  oldest;

   function automatic void clear_walk();
      walk_pos    = '0;
      walk_phase  = PH_KIND;
      opt_kind    = '0;
      opt_len     = '0;
      opt_offset  = '0;
      acc_a       = '0;
      acc_b       = '0;
      sack_blocks = '0;
      walk_stop   = STOP_NONE;
   endfunction

   function automatic void push_word(input rkind_type kind, input logic [31:0] a,
                                     input logic [31:0] b, input stop_type reason,
                                     input logic lst);
      result_type w;
      w.kind    = kind;
      w.value_a = a;
      w.value_b = b;
      w.reason  = reason;
      w.last    = lst;
      expected_words.push_back(w);
   endfunction

   // option whose last byte was just taken
   function automatic void report_option();
      if (opt_kind == KIND_MSS && opt_len == LEN_MSS)
         push_word(RK_MSS, {16'h0, acc_a[15:0]}, '0, STOP_NONE, 1'b0);
      else if (opt_kind == KIND_WSCALE && opt_len == LEN_WSCALE)
         push_word(RK_WSCALE, {24'h0, acc_a[7:0]}, '0, STOP_NONE, 1'b0);
      else if (opt_kind == KIND_SACKOK && opt_len == LEN_SACKOK)
         push_word(RK_SACKOK, '0, '0, STOP_NONE, 1'b0);
      else if (opt_kind == KIND_TSTAMP && opt_len == LEN_TSTAMP)
         push_word(RK_TSTAMP, acc_a, acc_b, STOP_NONE, 1'b0);
      else if (opt_kind == KIND_AUTH)
         push_word(RK_AUTH, '0, '0, STOP_NONE, 1'b0);
      walk_phase = PH_KIND;
   endfunction

   task automatic walk_option_byte(input logic [7:0] b, input logic mark,
                                   input logic [5:0] alen);
      int         area;
      logic [5:0] rel;
      area = (alen > MAX_AREA_BYTES_DEF) ? MAX_AREA_BYTES_DEF : int'(alen);
      if (mark)
         clear_walk();
      if (int'(walk_pos) >= area)
         return;
      case (walk_phase)
         PH_KIND: begin
            if (b == KIND_EOL) begin
               walk_stop  = STOP_EOL;
               walk_phase = PH_STOP;
            end else if (b != KIND_NOP) begin
               opt_kind = b;
               if (int'(walk_pos) + 1 >= area) begin
                  walk_stop  = STOP_MALFORMED;
                  walk_phase = PH_STOP;
               end else begin
                  walk_phase = PH_LEN;
               end
            end
         end
         PH_LEN: begin
            if (b < LEN_MIN || int'(walk_pos) - 1 + int'(b) > area) begin
               walk_stop  = STOP_MALFORMED;
               walk_phase = PH_STOP;
            end else begin
               opt_len     = b;
               acc_a       = '0;
               acc_b       = '0;
               sack_blocks = '0;
               opt_offset  = 6'd2;
               if (b == LEN_MIN)
                  report_option();
               else
                  walk_phase = PH_BODY;
            end
         end
         PH_BODY: begin
            rel = opt_offset - 6'd2;
            if (opt_kind == KIND_SACK) begin
               if (rel[2:0] < 3'd4)
                  acc_a = {acc_a[23:0], b};
               else
                  acc_b = {acc_b[23:0], b};
               if (rel[2:0] == 3'd7 && sack_blocks < MAX_SACK_BLOCKS_DEF) begin
                  push_word(RK_SACKBLK, acc_a, acc_b, STOP_NONE, 1'b0);
                  sack_blocks = sack_blocks + 3'd1;
               end
            end else if (rel < 6'd4) begin
               acc_a = {acc_a[23:0], b};
            end else begin
               acc_b = {acc_b[23:0], b};
            end
            if (int'(opt_offset) + 1 >= int'(opt_len)) begin
               if (opt_kind == KIND_SACK)
                  walk_phase = PH_KIND;
               else
                  report_option();
            end else begin
               opt_offset = opt_offset + 6'd1;
            end
         end
         default: ;
      endcase
      if (int'(walk_pos) + 1 == area)
         push_word(RK_DONE, '0, '0, (walk_stop == STOP_NONE) ? STOP_EXHAUSTED : walk_stop,
                   1'b1);
      walk_pos = walk_pos + 6'd1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_walk();
         expected_words.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_words.size() == 0) begin
               $error("result word with none expected: result_kind %0d", rsp.result_kind);
               mismatches++;
            end else begin
               oldest = expected_words.pop_front();
               if (rsp.result_kind !== oldest.kind) begin
                  $error("result_kind: expected %0d, actual %0d", oldest.kind,
                         rsp.result_kind);
                  mismatches++;
               end
               if (rsp.value_a !== oldest.value_a) begin
                  $error("value_a: expected %h, actual %h", oldest.value_a, rsp.value_a);
                  mismatches++;
               end
               if (rsp.value_b !== oldest.value_b) begin
                  $error("value_b: expected %h, actual %h", oldest.value_b, rsp.value_b);
                  mismatches++;
               end
               if (rsp.stop_reason !== oldest.reason) begin
                  $error("stop_reason: expected %0d, actual %0d", oldest.reason,
                         rsp.stop_reason);
                  mismatches++;
               end
               if (rsp.last !== oldest.last) begin
                  $error("last: expected %0d, actual %0d", oldest.last, rsp.last);
                  mismatches++;
               end
            end
         end
         if (req.valid && req.ready)
            walk_option_byte(req.option_byte, req.first, req.area_length);
      end
      pending <= expected_words.size();
   end

endmodule

// ===== sim/tcp_option_parser_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for tcp_option_parser_top: drives option bytes with random gaps
// and result stalls, gives the verdict. Depends on tcpop_pkg, tcpop_if, tcpop_result_check.
module tcp_option_parser_top_tb;
   import tcpop_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEM_TARGET = 650;
   localparam logic [7:0] KNOWN_KINDS [6] = '{KIND_MSS, KIND_WSCALE, KIND_SACKOK,
                                              KIND_SACK, KIND_TSTAMP, KIND_AUTH};

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   int   mismatches;
   int   pending;
   bit   send_quiet;
   bit   take_quiet;

   tcpop_req_if req_if ();
   tcpop_rsp_if rsp_if ();

   tcp_option_parser_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   tcpop_result_check result_check (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .rsp        (rsp_if),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tcp_option_parser_top_tb: FAIL");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap(input bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic mark, input logic [5:0] alen);
      int gap;
      gap = pick_gap(send_quiet);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.option_byte <= b;
      req_if.first       <= mark;
      req_if.area_length <= alen;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic send_segment(input logic [7:0] seg[$], input logic [5:0] alen,
                               input logic mark);
      foreach (seg[i])
         send_byte(seg[i], mark && i == 0, alen);
   endtask

   initial begin
      int hold;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         hold = pick_gap(take_quiet);
         if (hold > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   initial begin
      logic [7:0] seg[$];
      logic [7:0] kind;
      logic [5:0] alen;
      int         len;
      int         span;
      int         room;
      int         sent;
      int         r;
      int         extra;
      req_if.valid       <= 1'b0;
      req_if.option_byte <= '0;
      req_if.first       <= 1'b0;
      req_if.area_length <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // no first mark after reset; largest MSS
      seg = '{KIND_MSS, LEN_MSS, 8'hFF, 8'hFF};
      send_segment(seg, 6'd4, 1'b0);
      seg = '{KIND_WSCALE, LEN_WSCALE, 8'h00};
      send_segment(seg, 6'd3, 1'b1);
      seg = '{KIND_SACKOK, LEN_SACKOK};
      send_segment(seg, 6'd2, 1'b1);
      seg = '{KIND_AUTH, LEN_MIN};
      send_segment(seg, 6'd2, 1'b1);
      // length byte below minimum
      seg = '{8'hFE, 8'h01};
      send_segment(seg, 6'd2, 1'b1);
      // kind on the final byte, then a byte past the area
      seg = '{KIND_TSTAMP, 8'hFF};
      send_segment(seg, 6'd1, 1'b1);
      send_byte(8'hFF, 1'b1, 6'd0);
      // end of list, later bytes ignored
      seg = '{KIND_EOL, 8'hFF, KIND_TSTAMP};
      send_segment(seg, 6'd3, 1'b1);
      seg = '{KIND_TSTAMP, LEN_TSTAMP, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
              8'h00, 8'h00, 8'h00, 8'h00};
      send_segment(seg, 6'd10, 1'b1);

      sent = 0;
      while (sent < ITEM_TARGET) begin
         send_quiet = ($urandom_range(0, 7) == 0);
         take_quiet = ($urandom_range(0, 7) == 0);
         if ($urandom_range(0, 4) == 0) begin
            // noise: stray first marks, changing and out-of-range area lengths
            extra = $urandom_range(1, 12);
            repeat (extra)
               send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0,
                         6'($urandom_range(0, 63)));
            sent += extra;
         end else begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
               room = MAX_AREA_BYTES_DEF;
               alen = 6'($urandom_range(MAX_AREA_BYTES_DEF + 1, 63));
            end else begin
               room = (r < 4) ? $urandom_range(20, MAX_AREA_BYTES_DEF) : $urandom_range(1, 19);
               alen = 6'(room);
            end
            seg.delete();
            while (seg.size() < room) begin
               case ($urandom_range(0, 11))
                  0, 1: begin kind = KIND_NOP; len = 1; end
                  2: begin kind = KIND_MSS; len = int'(LEN_MSS); end
                  3: begin kind = KIND_WSCALE; len = int'(LEN_WSCALE); end
                  4: begin kind = KIND_SACKOK; len = int'(LEN_SACKOK); end
                  5: begin kind = KIND_TSTAMP; len = int'(LEN_TSTAMP); end
                  6, 7: begin
                     kind = KIND_SACK;
                     len = 2 + 8 * $urandom_range(1, MAX_SACK_BLOCKS_DEF);
                     if ($urandom_range(0, 3) == 0)
                        len = len - $urandom_range(1, 7);
                  end
                  8: begin kind = KIND_AUTH; len = $urandom_range(2, 16); end
                  9: begin
                     kind = KNOWN_KINDS[$urandom_range(0, 5)];
                     len = $urandom_range(2, 12);
                  end
                  10: begin
                     kind = 8'($urandom_range(2, 255));
                     len = $urandom_range(0, 8);
                  end
                  default: begin kind = KIND_EOL; len = 1; end
               endcase
               span = (kind == KIND_NOP || kind == KIND_EOL) ? 1 : ((len < 2) ? 2 : len);
               if (int'(seg.size()) + span > room && $urandom_range(0, 3) != 0)
                  kind = KIND_NOP;
               seg.push_back(kind);
               if (kind != KIND_NOP && kind != KIND_EOL) begin
                  seg.push_back(len[7:0]);
                  for (int j = 2; j < len; j++)
                     seg.push_back(8'($urandom_range(0, 255)));
               end
            end
            while (seg.size() > room)
               void'(seg.pop_back());
            send_segment(seg, alen, 1'b1);
            sent += room;
            if ($urandom_range(0, 5) == 0) begin
               extra = $urandom_range(1, 3);
               repeat (extra)
                  send_byte(8'($urandom_range(0, 255)), 1'b0, alen);
               sent += extra;
            end
         end
      end

      req_if.valid <= 1'b0;
      take_quiet = 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("tcp_option_parser_top_tb: PASS");
      else
         $display("tcp_option_parser_top_tb: FAIL");
      $finish;
   end

endmodule
